/* src/ptc_pkg.sv */
`default_nettype none
package ptc_pkg;

	localparam int unsigned DIV_W = 32;

	typedef enum logic [1:0] {
		REG_TEMP    = 2'd0,
		REG_PRESS_A = 2'd1,
		REG_PRESS_B = 2'd2,
		REG_PRESS_C = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coeffs_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
		return 32'($signed(v) >>> n);
	endfunction

endpackage
`default_nettype wire

/* src/pressure_temperature_compensation.sv */
// Throughput: one beat per cycle while the output is not stalled; a 32-stage
// restoring divider, one quotient bit per stage, sets the depth.
// Stall: every stage advances only when its output is free, nothing is lost.
// Reset: arst_n clears all valid bits and the coefficient registers to zero.
`default_nettype none
module pressure_temperature_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata, // raw_temperature, raw_pressure
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [103:0]     m_axis_tdata  // temperature_centi, fine_temperature, pressure_pa,
	                                       // pressure_invalid
);
	localparam int NS = 13 + ptc_pkg::DIV_W;

	logic [47:0] tc_q, pa_q, pb_q, pc_q;
	ptc_pkg::coeffs_t c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0;
		end else if (cfg_we) begin
			case (ptc_pkg::reg_idx_t'(cfg_index))
				ptc_pkg::REG_TEMP:    tc_q <= cfg_wdata;
				ptc_pkg::REG_PRESS_A: pa_q <= cfg_wdata;
				ptc_pkg::REG_PRESS_B: pb_q <= cfg_wdata;
				ptc_pkg::REG_PRESS_C: pc_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		c.t1 = tc_q[15:0]; c.t2 = tc_q[31:16]; c.t3 = tc_q[47:32];
		c.p1 = pa_q[15:0]; c.p2 = pa_q[31:16]; c.p3 = pa_q[47:32];
		c.p4 = pb_q[15:0]; c.p5 = pb_q[31:16]; c.p6 = pb_q[47:32];
		c.p7 = pc_q[15:0]; c.p8 = pc_q[31:16]; c.p9 = pc_q[47:32];
	end

	logic [NS:1] v_s;
	logic        adv [1:NS];
	assign s_axis_tready = adv[1];
	always_comb begin
		adv[NS] = !v_s[NS] || m_axis_tready;
		for (int i = NS - 1; i >= 1; i--) adv[i] = !v_s[i] || adv[i+1];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else begin
			if (adv[1]) v_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= NS; i++) if (adv[i]) v_s[i] <= v_s[i-1];
		end
	end

	// per-stage payload; fields live as long as needed
	logic [31:0] at_s1, d_s1, adcp_s1;
	logic [31:0] a_s2, dd_s2, adcp_s2;
	logic [31:0] a_s3, bt_s3, adcp_s3;
	logic [31:0] fine_s4, adcp_s4;
	logic [31:0] fine_s5, cen5_s5, pa_s5, adcp_s5;
	logic [31:0] fine_s6, cen_s6, pa_s6, sq_s6, adcp_s6;
	logic [31:0] fine_s7, cen_s7, b1_s7, b2_s7, pq_s7, pr_s7, adcp_s7;
	logic [31:0] fine_s8, cen_s8, b_s8, pa_s8, adcp_s8;
	logic [31:0] fine_s9, cen_s9, b_s9, x_s9;
	logic [31:0] fine_s10, cen_s10, den_s10, num_s10;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			at_s1   <= {15'd0, s_axis_tdata[19:3]} - {15'd0, c.t1, 1'b0};
			d_s1    <= {16'd0, s_axis_tdata[19:4]} - {16'd0, c.t1};
			adcp_s1 <= {12'd0, s_axis_tdata[39:20]};
		end
		if (adv[2]) begin
			a_s2    <= at_s1 * ptc_pkg::sx16(c.t2);
			dd_s2   <= d_s1 * d_s1;
			adcp_s2 <= adcp_s1;
		end
		if (adv[3]) begin
			a_s3    <= ptc_pkg::asr(a_s2, 11);
			bt_s3   <= ptc_pkg::asr(dd_s2, 12) * ptc_pkg::sx16(c.t3);
			adcp_s3 <= adcp_s2;
		end
		if (adv[4]) begin
			fine_s4 <= a_s3 + ptc_pkg::asr(bt_s3, 14);
			adcp_s4 <= adcp_s3;
		end
		if (adv[5]) begin
			fine_s5 <= fine_s4;
			cen5_s5 <= fine_s4 * 32'd5 + 32'd128;
			pa_s5   <= ptc_pkg::asr(fine_s4, 1) - 32'd64000;
			adcp_s5 <= adcp_s4;
		end
		if (adv[6]) begin
			fine_s6 <= fine_s5;
			cen_s6  <= ptc_pkg::asr(cen5_s5, 8);
			pa_s6   <= pa_s5;
			sq_s6   <= ptc_pkg::asr(pa_s5, 2) * ptc_pkg::asr(pa_s5, 2);
			adcp_s6 <= adcp_s5;
		end
		if (adv[7]) begin
			fine_s7 <= fine_s6;
			cen_s7  <= cen_s6;
			b1_s7   <= ptc_pkg::asr(sq_s6, 11) * ptc_pkg::sx16(c.p6);
			b2_s7   <= pa_s6 * ptc_pkg::sx16(c.p5);
			pq_s7   <= ptc_pkg::sx16(c.p3) * ptc_pkg::asr(sq_s6, 13);
			pr_s7   <= ptc_pkg::sx16(c.p2) * pa_s6;
			adcp_s7 <= adcp_s6;
		end
		if (adv[8]) begin
			fine_s8 <= fine_s7;
			cen_s8  <= cen_s7;
			b_s8    <= ptc_pkg::asr(b1_s7 + {b2_s7[30:0], 1'b0}, 2)
			           + {c.p4, 16'd0};
			pa_s8   <= 32'd32768 + ptc_pkg::asr(ptc_pkg::asr(pq_s7, 3)
			           + ptc_pkg::asr(pr_s7, 1), 18);
			adcp_s8 <= adcp_s7;
		end
		if (adv[9]) begin
			fine_s9 <= fine_s8;
			cen_s9  <= cen_s8;
			x_s9    <= pa_s8 * {16'd0, c.p1};
			b_s9    <= (32'd1048576 - adcp_s8) - ptc_pkg::asr(b_s8, 12);
		end
		if (adv[10]) begin
			fine_s10 <= fine_s9;
			cen_s10  <= cen_s9;
			den_s10  <= ptc_pkg::asr(x_s9, 15);
			num_s10  <= b_s9 * 32'd3125;
		end
	end

	// divider: stages 11 .. 10+DIV_W
	localparam int D0 = 11;
	localparam int DE = 10 + ptc_pkg::DIV_W;
	logic [31:0] rem_d [D0:DE], quo_d [D0:DE], num_d [D0:DE], den_d [D0:DE];
	logic [31:0] fin_d [D0:DE], cen_d [D0:DE];
	logic        big_d [D0:DE];
	logic [31:0] rem_n [D0:DE], quo_n [D0:DE], num_n [D0:DE];

	logic [31:0] div_num0;
	logic        big0;
	assign big0     = num_s10[31];
	assign div_num0 = big0 ? num_s10 : {num_s10[30:0], 1'b0};

	for (genvar k = D0; k <= DE; k++) begin : g_div
		logic [31:0] ri, qi, ni, di, fi, ci;
		logic        bi;
		if (k == D0) begin : g_first
			assign ri = '0; assign qi = '0; assign ni = div_num0; assign di = den_s10;
			assign fi = fine_s10; assign ci = cen_s10; assign bi = big0;
		end else begin : g_next
			assign ri = rem_d[k-1]; assign qi = quo_d[k-1];
			assign ni = num_d[k-1]; assign di = den_d[k-1];
			assign fi = fin_d[k-1]; assign ci = cen_d[k-1]; assign bi = big_d[k-1];
		end
		ptc_div_stage u_stage (
			.rem_in(ri), .quo_in(qi), .num_in(ni), .den(di),
			.rem_out(rem_n[k]), .quo_out(quo_n[k]), .num_out(num_n[k])
		);
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_d[k] <= rem_n[k];
				quo_d[k] <= quo_n[k];
				num_d[k] <= num_n[k];
				den_d[k] <= di;
				fin_d[k] <= fi;
				cen_d[k] <= ci;
				big_d[k] <= bi;
			end
		end
	end

	logic [31:0] fine_s43, cen_s43, p_s43, sq_s43, den_s43;
	logic [31:0] fine_s44, cen_s44, p_s44, pa_s44, pb_s44, den_s44;
	logic [31:0] fine_s45, cen_s45, p_s45;
	logic        inv_s45;

	always_ff @(posedge clk) begin
		if (adv[DE+1]) begin
			fine_s43 <= fin_d[DE];
			cen_s43  <= cen_d[DE];
			den_s43  <= den_d[DE];
			p_s43    <= big_d[DE] ? {quo_d[DE][30:0], 1'b0} : quo_d[DE];
			sq_s43   <= (big_d[DE] ? {3'd0, quo_d[DE][30:2]} : {3'd0, quo_d[DE][31:3]})
			            * (big_d[DE] ? {3'd0, quo_d[DE][30:2]} : {3'd0, quo_d[DE][31:3]});
		end
		if (adv[DE+2]) begin
			fine_s44 <= fine_s43;
			cen_s44  <= cen_s43;
			den_s44  <= den_s43;
			p_s44    <= p_s43;
			pa_s44   <= ptc_pkg::asr(ptc_pkg::sx16(c.p9) * {13'd0, sq_s43[31:13]}, 12);
			pb_s44   <= ptc_pkg::asr({2'd0, p_s43[31:2]} * ptc_pkg::sx16(c.p8), 13);
		end
		if (adv[DE+3]) begin
			fine_s45 <= fine_s44;
			cen_s45  <= cen_s44;
			inv_s45  <= den_s44 == '0;
			p_s45    <= (den_s44 == '0) ? '0
			            : p_s44 + ptc_pkg::asr(pa_s44 + pb_s44 + ptc_pkg::sx16(c.p7), 4);
		end
	end

	assign m_axis_tvalid = v_s[NS];
	assign m_axis_tdata  = {7'd0, inv_s45, p_s45, fine_s45, cen_s45};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tdata[95:64] == '0)
		else $error("invalid pressure not zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("pipeline stalls with free output");
endmodule
`default_nettype wire

/* src/ptc_div_stage.sv */
`default_nettype none
module ptc_div_stage (
	input  wire logic [31:0] rem_in,
	input  wire logic [31:0] quo_in,
	input  wire logic [31:0] num_in,
	input  wire logic [31:0] den,
	output logic      [31:0] rem_out,
	output logic      [31:0] quo_out,
	output logic      [31:0] num_out
);
	logic [32:0] trial;
	logic [32:0] diff;

	always_comb begin
		trial   = {rem_in, num_in[31]};
		diff    = trial - {1'b0, den};
		num_out = {num_in[30:0], 1'b0};
		if (!diff[32]) begin
			rem_out = diff[31:0];
			quo_out = {quo_in[30:0], 1'b1};
		end else begin
			rem_out = trial[31:0];
			quo_out = {quo_in[30:0], 1'b0};
		end
	end
endmodule
`default_nettype wire
